// ===== hdl/phase_min_consensus_node_top_assert.svh =====
`ifndef PHASE_MIN_CONSENSUS_NODE_TOP_ASSERT_SVH
`define PHASE_MIN_CONSENSUS_NODE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define PMC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define PMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hdl/pmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pmc_pkg;

  // Default sizes
  localparam int MAX_IN_DEF  = 4;
  localparam int MAX_OUT_DEF = 4;
  localparam int ID_BITS_DEF = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_IN_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_IDS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_IDS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAMETER  = 3'd6;

  // Register reset values
  localparam logic [2:0]         RST_IN_COUNT  = 3'd1;
  localparam logic [2:0]         RST_OUT_COUNT = 3'd1;
  localparam logic [31:0]        RST_IN_IDS    = 32'd0;
  localparam logic [31:0]        RST_OUT_IDS   = 32'd0;
  localparam logic signed [31:0] RST_LOCAL_MIN = 32'sd0;
  localparam logic [7:0]         RST_OWN_ID    = 8'd1;
  localparam logic [7:0]         RST_DIAMETER  = 8'd5;

  // Input opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_MSG   = 1'b1;

  localparam logic [7:0] CNT_SAT = 8'hFF;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] recv_value;
    logic [7:0]         sender_id;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         dest_node;
    logic signed [31:0] min_value;
    logic [7:0]         source_node;
    logic               is_final;
    logic               last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic apply;      // apply accepted item to node state
    logic bump_send;  // count one send round
    logic set_fin;    // mark protocol finished
    logic clr_idx;    // rewind emission index
    logic load_out;   // load next result into output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic skip;       // message arriving after finish
    logic running;    // some in-neighbour below diameter
    logic may_send;   // send round permitted
    logic has_out;    // at least one out-neighbour in use
    logic emit_last;  // result being loaded is the last one
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/pmc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pmc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire pmc_pkg::status_t status,
  output pmc_pkg::cmd_t        cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Sequence: take item, evaluate, emit any results
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !status.skip) begin
          cmd.apply = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!status.running) begin
          cmd.set_fin = 1'b1;
          cmd.clr_idx = 1'b1;
          state_nxt   = S_EMIT;
        end else if (status.may_send) begin
          cmd.bump_send = 1'b1;
          cmd.clr_idx   = 1'b1;
          state_nxt     = status.has_out ? S_EMIT : S_IDLE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          if (status.emit_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold output valid until the transaction completes
  always_comb begin
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pmc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pmc_dp #(
  parameter int MAX_IN  = pmc_pkg::MAX_IN_DEF,
  parameter int MAX_OUT = pmc_pkg::MAX_OUT_DEF,
  parameter int ID_BITS = pmc_pkg::ID_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [pmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pmc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire pmc_pkg::in_item_t                in_data,
  input  wire pmc_pkg::cmd_t                    cmd,
  output pmc_pkg::status_t                      status,
  output pmc_pkg::out_item_t                    out_data
);

  localparam int IDX_W = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int NW    = ($clog2(MAX_OUT + 1) > 3) ? $clog2(MAX_OUT + 1) : 3;

  // Configuration registers
  logic [2:0]         in_count_r, out_count_r;
  logic [31:0]        in_ids_r, out_ids_r;
  logic signed [31:0] local_min_r;
  logic [7:0]         own_id_r, diameter_r;

  // Node state
  logic [7:0]         cnt_r   [MAX_IN];
  logic [7:0]         cnt_nxt [MAX_IN];
  logic [7:0]         send_r, send_nxt;
  logic signed [31:0] min_r, min_nxt;
  logic               fin_r, fin_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;

  pmc_pkg::out_item_t out_r, out_nxt;

  logic [ID_BITS-1:0] in_id  [MAX_IN];
  logic [ID_BITS-1:0] out_id [MAX_OUT];
  logic [ID_BITS-1:0] sender;
  logic [NW-1:0]      out_cnt_ext, nout;
  logic               running, may_send;

  // Unpack neighbour ids; entries past the packed word read as zero
  always_comb begin
    for (int i = 0; i < MAX_IN; i++) begin
      in_id[i] = ID_BITS'(in_ids_r >> (i * ID_BITS));
    end
    for (int j = 0; j < MAX_OUT; j++) begin
      out_id[j] = ID_BITS'(out_ids_r >> (j * ID_BITS));
    end
  end

  assign sender = ID_BITS'(in_data.sender_id);

  // Clamp out-neighbour count
  assign out_cnt_ext = NW'(out_count_r);
  assign nout = (out_cnt_ext > NW'(MAX_OUT)) ? NW'(MAX_OUT) : out_cnt_ext;

  // Round checks over in-neighbours in use
  always_comb begin
    running  = 1'b0;
    may_send = (send_r < diameter_r);
    for (int i = 0; i < MAX_IN; i++) begin
      if (int'(in_count_r) > i) begin
        if (cnt_r[i] < diameter_r) running = 1'b1;
        if (cnt_r[i] < send_r) may_send = 1'b0;
      end
    end
  end

  always_comb begin
    status.skip      = (in_data.opcode == pmc_pkg::OP_MSG) && fin_r;
    status.running   = running;
    status.may_send  = may_send;
    status.has_out   = (nout != '0);
    status.emit_last = fin_r || ((NW'(idx_r) + NW'(1)) == nout);
  end

  // Next node state
  always_comb begin
    cnt_nxt  = cnt_r;
    send_nxt = send_r;
    min_nxt  = min_r;
    fin_nxt  = fin_r;
    idx_nxt  = idx_r;
    if (cmd.apply) begin
      if (in_data.opcode == pmc_pkg::OP_START) begin
        for (int i = 0; i < MAX_IN; i++) cnt_nxt[i] = '0;
        send_nxt = '0;
        min_nxt  = local_min_r;
        fin_nxt  = 1'b0;
      end else begin
        for (int i = 0; i < MAX_IN; i++) begin
          if ((int'(in_count_r) > i) && (in_id[i] == sender) &&
              (cnt_r[i] != pmc_pkg::CNT_SAT)) begin
            cnt_nxt[i] = cnt_r[i] + 8'd1;
          end
        end
        if (in_data.recv_value < min_r) min_nxt = in_data.recv_value;
      end
    end
    if (cmd.bump_send) send_nxt = send_r + 8'd1;
    if (cmd.set_fin) fin_nxt = 1'b1;
    if (cmd.clr_idx) idx_nxt = '0;
    else if (cmd.load_out) idx_nxt = idx_r + IDX_W'(1);
  end

  // Build next result
  always_comb begin
    out_nxt.dest_node   = fin_r ? 8'd0 : 8'(out_id[idx_r]);
    out_nxt.min_value   = min_r;
    out_nxt.source_node = own_id_r;
    out_nxt.is_final    = fin_r;
    out_nxt.last        = status.emit_last;
  end

  // Configuration writes and state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_count_r  <= pmc_pkg::RST_IN_COUNT;
      out_count_r <= pmc_pkg::RST_OUT_COUNT;
      in_ids_r    <= pmc_pkg::RST_IN_IDS;
      out_ids_r   <= pmc_pkg::RST_OUT_IDS;
      local_min_r <= pmc_pkg::RST_LOCAL_MIN;
      own_id_r    <= pmc_pkg::RST_OWN_ID;
      diameter_r  <= pmc_pkg::RST_DIAMETER;
      for (int i = 0; i < MAX_IN; i++) cnt_r[i] <= '0;
      send_r <= '0;
      min_r  <= '0;
      fin_r  <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pmc_pkg::CFG_IN_COUNT:  in_count_r  <= cfg_data[2:0];
          pmc_pkg::CFG_OUT_COUNT: out_count_r <= cfg_data[2:0];
          pmc_pkg::CFG_IN_IDS:    in_ids_r    <= cfg_data;
          pmc_pkg::CFG_OUT_IDS:   out_ids_r   <= cfg_data;
          pmc_pkg::CFG_LOCAL_MIN: local_min_r <= signed'(cfg_data);
          pmc_pkg::CFG_OWN_ID:    own_id_r    <= cfg_data[7:0];
          pmc_pkg::CFG_DIAMETER:  diameter_r  <= cfg_data[7:0];
          default: ;
        endcase
      end
      cnt_r  <= cnt_nxt;
      send_r <= send_nxt;
      min_r  <= min_nxt;
      fin_r  <= fin_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (cmd.load_out) out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// ===== hdl/phase_min_consensus_node_top.sv =====
// An item is applied in its accept cycle and evaluated in the next one; its first result is
// loaded into the output register in S_EMIT once it is free. A message after finish is dropped.
// Throughput: an item gives n = 0..4 results, one result per cycle from the single output
// register while out_stall is low; no new item is taken before its last result is loaded.
// Reset (rst_n low, synchronous): registers to their defaults, counts, send count, minimum and
// finished flag cleared, output empty. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "phase_min_consensus_node_top_assert.svh"

module phase_min_consensus_node_top #(
  parameter int MAX_IN  = pmc_pkg::MAX_IN_DEF,
  parameter int MAX_OUT = pmc_pkg::MAX_OUT_DEF,
  parameter int ID_BITS = pmc_pkg::ID_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire pmc_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output pmc_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_we,
  input  wire logic [pmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pmc_pkg::CFG_DATA_W-1:0] cfg_data
);

  pmc_pkg::cmd_t    cmd;
  pmc_pkg::status_t status;

  pmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  pmc_dp #(
    .MAX_IN  (MAX_IN),
    .MAX_OUT (MAX_OUT),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

  // Node state is applied only from an accepted transaction
  `PMC_ASSERT_NOW(a_apply_on_accept, cmd.apply, in_valid && !in_stall)
  // No new input while results are still being emitted
  `PMC_ASSERT_NOW(a_no_accept_in_emit, cmd.load_out, in_stall)
  // A loaded result is offered in the next cycle
  `PMC_ASSERT_NEXT(a_load_shows, cmd.load_out, out_valid)
  // The final report always closes its item
  `PMC_ASSERT_NOW(a_final_is_last, out_valid && out_data.is_final, out_data.last)

endmodule

`default_nettype wire
